FILE: rtl/block_buffer_cache_refcount_unit_macros.svh
// Assertion macros for the buffer cache refcount unit.
// BBCR_ASSERT checks a property on every clock edge outside reset.
// BBCR_ASSERT_NEXT checks that cons holds in the cycle after ante.
`ifndef BLOCK_BUFFER_CACHE_REFCOUNT_UNIT_MACROS_SVH
`define BLOCK_BUFFER_CACHE_REFCOUNT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BBCR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bbcr: assertion failed");
`define BBCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bbcr: assertion failed");
`else
`define BBCR_ASSERT(lbl, clk, rstn, prop)
`define BBCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/bbcr_pkg.sv
package bbcr_pkg;

    localparam int BLK_W  = 32;
    localparam int BSZ_W  = 12;
    localparam int REL_W  = 4;
    localparam int STAT_W = 3;
    localparam int POS_W  = 43;
    // wide enough for any slot index and for the slot count itself
    localparam int IDX_W  = 9;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BSZ_W-1:0] BSZ_RESET = 12'd2048;

    localparam logic CMD_GET     = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FILLED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_RD_ERR   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_FREE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;

    typedef struct packed {
        logic             is_release;
        logic             rel_ok;
        logic [BLK_W-1:0] blk;
        logic [REL_W-1:0] rel;
        logic             ok;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [REL_W-1:0]  slot;
        logic [POS_W-1:0]  pos;
    } t_res;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

FILE: rtl/bbcr_fifo.sv
module bbcr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output bbcr_pkg::t_qstat  o_stat
);

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: rtl/bbcr_front.sv
module bbcr_front #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_cmd,
    input  logic [bbcr_pkg::BLK_W-1:0]        i_block_number,
    input  logic [bbcr_pkg::REL_W-1:0]        i_release_slot,
    input  logic                              i_fill_ok,
    output bbcr_pkg::t_req                    o_req,
    output logic                              o_q_push,
    input  logic                              i_q_full
);

    localparam int IW = bbcr_pkg::IDX_W;
    localparam int RW = bbcr_pkg::REL_W;

    logic            r_valid;
    bbcr_pkg::t_req  r_req;
    bbcr_pkg::t_req  n_req;
    logic            accept;
    logic [IW-1:0]   rel_wide;

    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_req    = r_req;
    assign rel_wide = {{(IW - RW){1'b0}}, i_release_slot};

    // classify: command decode and release range check
    always_comb begin
        n_req.is_release = (i_cmd == bbcr_pkg::CMD_RELEASE);
        n_req.rel_ok     = (rel_wide < IW'(NUM_SLOTS));
        n_req.blk        = i_block_number;
        n_req.rel        = i_release_slot;
        n_req.ok         = i_fill_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= n_req;
        end
    end

endmodule

FILE: rtl/bbcr_back.sv
`include "block_buffer_cache_refcount_unit_macros.svh"
module bbcr_back #(
    parameter int NUM_SLOTS  = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [bbcr_pkg::BSZ_W-1:0]        i_block_size,
    input  bbcr_pkg::t_req                    i_req,
    input  bbcr_pkg::t_qstat                  i_req_q,
    output logic                              o_req_pop,
    output bbcr_pkg::t_res                    o_res,
    output logic                              o_res_push,
    input  bbcr_pkg::t_qstat                  i_res_q
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IW     = bbcr_pkg::IDX_W;
    localparam int RW     = bbcr_pkg::REL_W;
    localparam int BW     = bbcr_pkg::BLK_W;
    localparam int PW     = bbcr_pkg::POS_W;
    localparam int MW     = bbcr_pkg::BLK_W + bbcr_pkg::BSZ_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    // slot state
    logic [BW-1:0]         r_tag [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_vld;
    logic [COUNT_BITS-1:0] r_cnt [NUM_SLOTS];
    logic [SLOT_W-1:0]     r_ptr;

    // sequencer
    logic [1:0]            r_state;
    bbcr_pkg::t_req        r_req;
    logic [PW-1:0]         r_pos;
    logic [NUM_SLOTS-1:0]  r_hitv;
    logic [NUM_SLOTS-1:0]  r_zerov;
    logic [SLOT_W-1:0]     r_h;
    logic                  r_hit_any;
    logic [SLOT_W-1:0]     r_f;
    logic                  r_f_any;

    logic [NUM_SLOTS-1:0]  n_hitv;
    logic [NUM_SLOTS-1:0]  n_zerov;
    logic [MW-1:0]         prod;
    logic [SLOT_W-1:0]     n_h;
    logic                  n_hit_any;
    logic [SLOT_W-1:0]     n_f;
    logic                  n_f_any;

    logic                  fire;
    logic [IW-1:0]         rel_wide;
    logic [SLOT_W-1:0]     rel_idx;
    logic [SLOT_W-1:0]     sel;
    logic [COUNT_BITS-1:0] sel_cnt;
    logic [SLOT_W-1:0]     free;
    logic                  have_free;
    logic [IW-1:0]         h_wide;
    logic [IW-1:0]         free_wide;
    logic                  cnt_we;
    logic [SLOT_W-1:0]     cnt_idx;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  tag_we;
    logic [SLOT_W-1:0]     n_ptr;
    bbcr_pkg::t_res        res;

    assign o_req_pop  = (r_state == S_IDLE) && !i_req_q.empty;
    assign fire       = (r_state == S_UPD) && !i_res_q.full;
    assign o_res_push = fire;
    assign o_res      = res;

    // tag compare and free-slot candidates, all slots at once
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_hitv[i]  = r_vld[i] && (r_tag[i] == r_req.blk);
            n_zerov[i] = (r_cnt[i] == '0);
        end
    end

    assign prod = r_req.blk * i_block_size;

    // first hit; first idle slot at or after the pickup pointer
    always_comb begin
        n_h       = '0;
        n_hit_any = 1'b0;
        n_f       = '0;
        n_f_any   = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_hitv[i]) begin
                n_h       = SLOT_W'(i);
                n_hit_any = 1'b1;
            end
            if (r_zerov[i] && (SLOT_W'(i) >= r_ptr)) begin
                n_f     = SLOT_W'(i);
                n_f_any = 1'b1;
            end
        end
    end

    assign rel_wide  = {{(IW - RW){1'b0}}, r_req.rel};
    assign rel_idx   = rel_wide[SLOT_W-1:0];
    assign sel       = r_req.is_release ? rel_idx : r_h;
    assign sel_cnt   = r_cnt[sel];
    assign h_wide    = IW'(r_h);
    assign free_wide = IW'(free);

    always_comb begin
        have_free = 1'b0;
        free      = '0;
        if (r_f_any) begin
            have_free = 1'b1;
            free      = r_f;
        end else if (r_zerov[0]) begin
            // walk wrapped to slot 0 and slot 0 is idle
            have_free = 1'b1;
        end
    end

    always_comb begin
        res       = '0;
        cnt_we    = 1'b0;
        cnt_idx   = sel;
        cnt_wdata = sel_cnt;
        tag_we    = 1'b0;
        n_ptr     = r_ptr;
        if (r_req.is_release) begin
            res.status = bbcr_pkg::ST_RELEASED;
            res.slot   = r_req.rel;
            if (r_req.rel_ok && (sel_cnt != '0)) begin
                cnt_we    = 1'b1;
                cnt_wdata = sel_cnt - COUNT_BITS'(1);
            end
        end else if (r_hit_any) begin
            res.status = bbcr_pkg::ST_HIT;
            res.slot   = h_wide[RW-1:0];
            if (sel_cnt != CNT_MAX) begin
                cnt_we    = 1'b1;
                cnt_wdata = sel_cnt + COUNT_BITS'(1);
            end
            // pointer keeps the steps taken over busy slots below the hit
            if (r_h > r_ptr) begin
                n_ptr = (r_f_any && (r_f < r_h)) ? r_f : r_h;
            end
        end else if (!have_free) begin
            res.status = bbcr_pkg::ST_NO_FREE;
            n_ptr      = '0;
        end else begin
            tag_we   = 1'b1;
            res.slot = free_wide[RW-1:0];
            res.pos  = r_pos;
            if (r_req.ok) begin
                res.status = bbcr_pkg::ST_FILLED;
                cnt_we     = 1'b1;
                cnt_idx    = free;
                cnt_wdata  = COUNT_BITS'(1);
                n_ptr      = (free == SLOT_W'(NUM_SLOTS - 1)) ? '0 : free + SLOT_W'(1);
            end else begin
                res.status = bbcr_pkg::ST_RD_ERR;
                n_ptr      = free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
            r_vld   <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_req_pop) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP:  r_state <= S_PICK;
                S_PICK: r_state <= S_UPD;
                S_UPD: begin
                    if (fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (fire) begin
                r_ptr <= n_ptr;
                if (cnt_we) begin
                    r_cnt[cnt_idx] <= cnt_wdata;
                end
                if (tag_we) begin
                    r_vld[free] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) begin
            r_req <= i_req;
        end
        if (r_state == S_CMP) begin
            r_hitv  <= n_hitv;
            r_zerov <= n_zerov;
            r_pos   <= prod[PW-1:0];
        end
        if (r_state == S_PICK) begin
            r_h       <= n_h;
            r_hit_any <= n_hit_any;
            r_f       <= n_f;
            r_f_any   <= n_f_any;
        end
        if (fire && tag_we) begin
            r_tag[free] <= r_req.blk;
        end
    end

    `BBCR_ASSERT(a_ptr_range, i_clk, i_rst_n, r_ptr <= SLOT_W'(NUM_SLOTS - 1))
    `BBCR_ASSERT(a_pop_idle, i_clk, i_rst_n, o_req_pop |-> (r_state == S_IDLE))
    `BBCR_ASSERT(a_push_upd, i_clk, i_rst_n, o_res_push |-> (r_state == S_UPD) && !i_res_q.full)
    `BBCR_ASSERT_NEXT(a_cmp_pick, i_clk, i_rst_n, r_state == S_CMP, r_state == S_PICK)
    `BBCR_ASSERT_NEXT(a_pop_cmp, i_clk, i_rst_n, o_req_pop, r_state == S_CMP)

endmodule

FILE: rtl/block_buffer_cache_refcount_unit.sv
// Buffer cache tag and reference count manager, round-robin slot pickup.
// Input channel: an item is taken on a clock edge with push high and full low.
//   A get item (i_cmd 0) looks up i_block_number; a release item (i_cmd 1)
//   drops the count of slot i_release_slot. i_fill_ok is the device read
//   outcome for a get that claims a slot.
// Result channel: while empty is low the oldest result sits on o_status,
//   o_slot_index and o_read_position; pop high takes it on that edge.
// Config channel: i_block_size is written on an edge with valid and ready
//   high; ready is always high. Write it only while the block is idle.
// Path: an item passes the input stage and the request queue, then the
//   compare, pick and update steps of the engine, into the result queue.
// Flow: the engine takes no new item until its four-step sequence (dequeue,
//   tag compare, priority pick, state update) for the last one is through.
// Reset: all slots invalid, all counts zero, pickup pointer at slot 0, block
//   size 2048, both queues empty. No clearing pass is needed.
// Stall: with the result queue full the engine holds in its update step;
//   the request queue and input stage then fill and full goes high.
module block_buffer_cache_refcount_unit #(
    parameter int NUM_SLOTS  = 16,
    parameter int COUNT_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // requests
    input  logic                               push,
    output logic                               full,
    input  logic                               i_cmd,
    input  logic [bbcr_pkg::BLK_W-1:0]         i_block_number,
    input  logic [bbcr_pkg::REL_W-1:0]         i_release_slot,
    input  logic                               i_fill_ok,
    // results
    output logic                               empty,
    input  logic                               pop,
    output logic [bbcr_pkg::STAT_W-1:0]        o_status,
    output logic [bbcr_pkg::REL_W-1:0]         o_slot_index,
    output logic [bbcr_pkg::POS_W-1:0]         o_read_position,
    // configuration
    input  logic                               valid,
    output logic                               ready,
    input  logic [bbcr_pkg::BSZ_W-1:0]         i_block_size
);

    localparam int REQ_W = $bits(bbcr_pkg::t_req);
    localparam int RES_W = $bits(bbcr_pkg::t_res);

    logic [bbcr_pkg::BSZ_W-1:0] r_block_size;

    bbcr_pkg::t_req    front_req;
    logic              front_push;
    bbcr_pkg::t_qstat  req_q;
    logic [REQ_W-1:0]  req_q_data;
    bbcr_pkg::t_req    eng_req;
    logic              eng_pop;
    bbcr_pkg::t_res    eng_res;
    logic              eng_push;
    bbcr_pkg::t_qstat  res_q;
    logic [RES_W-1:0]  res_q_data;
    bbcr_pkg::t_res    out_res;

    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= bbcr_pkg::BSZ_RESET;
        end else if (valid && ready) begin
            r_block_size <= i_block_size;
        end
    end

    // front: input stage and command classification
    bbcr_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_cmd          (i_cmd),
        .i_block_number (i_block_number),
        .i_release_slot (i_release_slot),
        .i_fill_ok      (i_fill_ok),
        .o_req          (front_req),
        .o_q_push       (front_push),
        .i_q_full       (req_q.full)
    );

    // short request queue decouples front and engine
    bbcr_fifo #(
        .WIDTH (REQ_W),
        .DEPTH (bbcr_pkg::QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_req),
        .i_pop   (eng_pop),
        .o_data  (req_q_data),
        .o_stat  (req_q)
    );

    assign eng_req = bbcr_pkg::t_req'(req_q_data);

    // back: slot state and the lookup / claim / release engine
    bbcr_back #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_size (r_block_size),
        .i_req        (eng_req),
        .i_req_q      (req_q),
        .o_req_pop    (eng_pop),
        .o_res        (eng_res),
        .o_res_push   (eng_push),
        .i_res_q      (res_q)
    );

    // result queue: engine keeps going while a result waits
    bbcr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (bbcr_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (eng_push),
        .i_data  (eng_res),
        .i_pop   (pop),
        .o_data  (res_q_data),
        .o_stat  (res_q)
    );

    assign out_res         = bbcr_pkg::t_res'(res_q_data);
    assign empty           = res_q.empty;
    assign o_status        = out_res.status;
    assign o_slot_index    = out_res.slot;
    assign o_read_position = out_res.pos;

endmodule
